// ----- rtl/core/spos_pkg.sv -----
// shared types, constants and helper functions for the screen projection block
package spos_pkg;

    localparam int MAX_SCREEN_SIDE = 1024;
    localparam int SIDE_W          = $clog2(MAX_SCREEN_SIDE + 1);
    localparam int COL_W           = $clog2(MAX_SCREEN_SIDE);
    localparam int CALC_W          = 17;

    localparam logic [1:0] REQ_WALL   = 2'd0;
    localparam logic [1:0] REQ_SPRITE = 2'd1;
    localparam logic [1:0] REQ_WEAPON = 2'd2;

    localparam logic [1:0] CFG_VIEW_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_VIEW_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_CENTRE_ROW  = 2'd2;
    localparam logic [1:0] CFG_EYE_HEIGHT  = 2'd3;

    localparam logic [SIDE_W-1:0] VIEW_WIDTH_RST  = SIDE_W'(320);
    localparam logic [SIDE_W-1:0] VIEW_HEIGHT_RST = SIDE_W'(168);
    localparam logic [26:0]       CENTRE_ROW_RST  = 27'd5505024;
    localparam logic [31:0]       EYE_HEIGHT_RST  = 32'd2686976;

    localparam logic [31:0] NEAR_LIMIT = 32'h0002_0000;
    localparam logic [31:0] FAR_LIMIT  = 32'h0000_0800;
    localparam logic [9:0]  DEPTH_MAX  = 10'd999;
    // span 0x1f800 is 63 << 11: shift by 11, then multiply by ceil(2^22 / 63)
    localparam int          DEPTH_SHIFT       = 11;
    localparam logic [16:0] DEPTH_RECIP       = 17'd66577;
    localparam int          DEPTH_RECIP_SHIFT = 22;
    localparam logic [CALC_W-1:0] GUN_RAISE   = CALC_W'(32);
    localparam logic [COL_W-1:0]  MIN_THING_ROWS = COL_W'(5);

    typedef struct packed {
        logic [1:0]         req_type;
        logic signed [15:0] first_col;
        logic signed [15:0] last_col;
        logic signed [31:0] near_scale;
        logic signed [31:0] far_scale;
        logic signed [31:0] top_z;
        logic signed [31:0] bottom_z;
        logic [1:0]         wall_shape;
        logic [7:0]         thing_kind;
        logic               source_present;
        logic signed [31:0] gun_x;
        logic signed [31:0] gun_y;
    } spos_item_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic             keep;
        logic [COL_W-1:0] col_a;
        logic [COL_W-1:0] col_b;
        logic [COL_W-1:0] near_top_row;
        logic [COL_W-1:0] near_bottom_row;
        logic [COL_W-1:0] far_top_row;
        logic [COL_W-1:0] far_bottom_row;
        logic [9:0]       depth;
        logic [1:0]       shape_out;
        logic [7:0]       kind_of_thing;
        logic [COL_W-1:0] thing_rows;
    } spos_result_t;

    // register value forced into 1..MAX_SCREEN_SIDE
    function automatic logic [SIDE_W-1:0] clamp_side(input logic [SIDE_W-1:0] raw);
        logic [SIDE_W-1:0] r;
        begin
            r = raw;
            if (raw == '0)
            begin
                r = SIDE_W'(1);
            end
            else if (raw > SIDE_W'(MAX_SCREEN_SIDE))
            begin
                r = SIDE_W'(MAX_SCREEN_SIDE);
            end
            return r;
        end
    endfunction

    // signed column within 0..side-1
    function automatic logic col_ok(input logic signed [15:0] x,
                                    input logic [SIDE_W-1:0] side);
        logic ok;
        begin
            ok = !x[15] && ({1'b0, x[14:0]} < 16'(side));
            return ok;
        end
    endfunction

    function automatic logic [COL_W-1:0] clamp_to(input logic signed [CALC_W-1:0] v,
                                                 input logic [SIDE_W-1:0] side);
        logic [COL_W-1:0] r;
        logic [SIDE_W-1:0] top;
        begin
            top = side - SIDE_W'(1);
            if (v[CALC_W-1])
            begin
                r = '0;
            end
            else if (v >= $signed({{(CALC_W-SIDE_W){1'b0}}, side}))
            begin
                r = top[COL_W-1:0];
            end
            else
            begin
                r = v[COL_W-1:0];
            end
            return r;
        end
    endfunction

    // scale of zero or less counts as 1
    function automatic logic signed [31:0] fix_scale(input logic signed [31:0] s);
        logic signed [31:0] r;
        begin
            r = (s <= 0) ? 32'sd1 : s;
            return r;
        end
    endfunction

endpackage

// ----- rtl/core/screen_projection_of_segments.sv -----
// screen projection of wall segments, sprites and the weapon overlay
//
//  channel | signals                           | direction | content
//  item    | item_valid, item_ready, item      | in        | one request per handshake
//  result  | result_valid, result_ready, result| out       | one result per request
//  cfg     | cfg_valid, cfg_ready, cfg_index,  | in        | register write, always ready
//          | cfg_data                          |           |
//
// four register stages: range checks and height differences, the four 32x32
// row multipliers, row subtract and clamp with the depth reciprocal multiply,
// then the output register; one request enters each cycle while the result
// side is ready. reset clears stage valids and loads the register defaults.
// a stall only holds occupied stages, so empty stages still take requests.
module screen_projection_of_segments (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  spos_pkg::spos_item_t  item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output spos_pkg::spos_result_t result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [1:0]            cfg_index,
    input  logic [31:0]           cfg_data
);
    import spos_pkg::*;

    typedef struct packed {
        logic [1:0]                req;
        logic                      keep;
        logic [COL_W-1:0]          x1;
        logic [COL_W-1:0]          x2;
        logic [COL_W-1:0]          mid;
        logic signed [31:0]        s_near;
        logic signed [31:0]        s_far;
        logic signed [31:0]        rel_top;
        logic signed [31:0]        rel_bot;
        logic                      d_near;
        logic                      d_far;
        logic [16:0]               d_diff;
        logic [1:0]                shape;
        logic [7:0]                thing;
        logic signed [CALC_W-1:0]  wx;
        logic signed [CALC_W-1:0]  wy;
    } s1_t;

    typedef struct packed {
        logic [1:0]                req;
        logic                      keep;
        logic [COL_W-1:0]          x1;
        logic [COL_W-1:0]          x2;
        logic [COL_W-1:0]          mid;
        logic                      d_near;
        logic                      d_far;
        logic [26:0]               d_scaled;
        logic [31:0]               p_nt;
        logic [31:0]               p_nb;
        logic [31:0]               p_ft;
        logic [31:0]               p_fb;
        logic [1:0]                shape;
        logic [7:0]                thing;
        logic signed [CALC_W-1:0]  wx;
        logic signed [CALC_W-1:0]  wy;
    } s2_t;

    typedef struct packed {
        logic [1:0]       req;
        logic             keep;
        logic [COL_W-1:0] x1;
        logic [COL_W-1:0] x2;
        logic [COL_W-1:0] mid;
        logic [9:0]       depth;
        logic [COL_W-1:0] nt;
        logic [COL_W-1:0] nb;
        logic [COL_W-1:0] ft;
        logic [COL_W-1:0] fb;
        logic [1:0]       shape;
        logic [7:0]       thing;
        logic [COL_W-1:0] gun_col;
        logic [COL_W-1:0] gun_row;
    } s3_t;

    logic [SIDE_W-1:0] vw_reg;
    logic [SIDE_W-1:0] vh_reg;
    logic [26:0]       centre_reg;
    logic [31:0]       eye_reg;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic en1, en2, en3, en4;

    s1_t          s1_next, s1_reg;
    s2_t          s2_next, s2_reg;
    s3_t          s3_next, s3_reg;
    spos_result_t out_next, out_reg;

    logic signed [63:0] prod_nt, prod_nb, prod_ft, prod_fb;
    logic signed [31:0] rel_top, rel_bot, s_near;
    logic [10:0]        mid_sum;
    logic               x_ok;
    logic [15:0]        d_coarse;
    logic [32:0]        d_prod;
    logic [31:0]        fy_nt, fy_nb, fy_ft, fy_fb;
    logic signed [COL_W:0] thing_h;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vw_reg     <= VIEW_WIDTH_RST;
            vh_reg     <= VIEW_HEIGHT_RST;
            centre_reg <= CENTRE_ROW_RST;
            eye_reg    <= EYE_HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_VIEW_WIDTH:  vw_reg     <= clamp_side(cfg_data[SIDE_W-1:0]);
                CFG_VIEW_HEIGHT: vh_reg     <= clamp_side(cfg_data[SIDE_W-1:0]);
                CFG_CENTRE_ROW:  centre_reg <= cfg_data[26:0];
                CFG_EYE_HEIGHT:  eye_reg    <= cfg_data;
                default:         ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    assign en4 = !out_valid_reg || result_ready;
    assign en3 = !s3_valid_reg || en4;
    assign en2 = !s2_valid_reg || en3;
    assign en1 = !s1_valid_reg || en2;

    assign item_ready   = en1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                s1_valid_reg <= item_valid;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (en4)
            begin
                out_valid_reg <= s3_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_reg <= s1_next;
        end
        if (en2)
        begin
            s2_reg <= s2_next;
        end
        if (en3)
        begin
            s3_reg <= s3_next;
        end
        if (en4)
        begin
            out_reg <= out_next;
        end
    end

    // ---------------- stage 1: checks, height differences ----------------
    assign rel_top = item.top_z - $signed(eye_reg);
    assign rel_bot = item.bottom_z - $signed(eye_reg);
    assign s_near  = fix_scale(item.near_scale);
    assign x_ok    = col_ok(item.first_col, vw_reg) && col_ok(item.last_col, vw_reg);
    assign mid_sum = {1'b0, item.first_col[COL_W-1:0]} + {1'b0, item.last_col[COL_W-1:0]};

    always_comb
    begin
        s1_next         = '0;
        s1_next.req     = item.req_type;
        s1_next.x1      = item.first_col[COL_W-1:0];
        s1_next.x2      = item.last_col[COL_W-1:0];
        s1_next.mid     = mid_sum[COL_W:1];
        s1_next.s_near  = s_near;
        s1_next.s_far   = fix_scale(item.far_scale);
        s1_next.rel_top = rel_top;
        s1_next.rel_bot = rel_bot;
        s1_next.d_near  = s_near > $signed(NEAR_LIMIT);
        s1_next.d_far   = s_near < $signed(FAR_LIMIT);
        s1_next.d_diff  = s_near[16:0] - FAR_LIMIT[16:0];
        s1_next.shape   = item.wall_shape;
        s1_next.thing   = item.thing_kind;
        s1_next.wx      = CALC_W'($signed(item.gun_x[31:16]))
                        + $signed({{(CALC_W-SIDE_W+1){1'b0}}, vw_reg[SIDE_W-1:1]});
        s1_next.wy      = CALC_W'($signed(item.gun_y[31:16]))
                        + $signed({{(CALC_W-SIDE_W){1'b0}}, vh_reg})
                        - $signed(GUN_RAISE);
        case (item.req_type)
            REQ_WALL:
            begin
                s1_next.keep = x_ok && (item.first_col <= item.last_col)
                             && item.source_present;
            end
            REQ_SPRITE: s1_next.keep = x_ok;
            REQ_WEAPON: s1_next.keep = item.source_present;
            default:    s1_next.keep = 1'b0;
        endcase
    end

    // ---------------- stage 2: projection multipliers ----------------
    assign prod_nt = s1_reg.rel_top * s1_reg.s_near;
    assign prod_nb = s1_reg.rel_bot * s1_reg.s_near;
    assign prod_ft = s1_reg.rel_top * s1_reg.s_far;
    assign prod_fb = s1_reg.rel_bot * s1_reg.s_far;

    always_comb
    begin
        s2_next          = '0;
        s2_next.req      = s1_reg.req;
        s2_next.keep     = s1_reg.keep;
        s2_next.x1       = s1_reg.x1;
        s2_next.x2       = s1_reg.x2;
        s2_next.mid      = s1_reg.mid;
        s2_next.d_near   = s1_reg.d_near;
        s2_next.d_far    = s1_reg.d_far;
        s2_next.d_scaled = 27'(s1_reg.d_diff * 27'(DEPTH_MAX));
        s2_next.p_nt     = prod_nt[47:16];
        s2_next.p_nb     = prod_nb[47:16];
        s2_next.p_ft     = prod_ft[47:16];
        s2_next.p_fb     = prod_fb[47:16];
        s2_next.shape    = s1_reg.shape;
        s2_next.thing    = s1_reg.thing;
        s2_next.wx       = s1_reg.wx;
        s2_next.wy       = s1_reg.wy;
    end

    // ---------------- stage 3: rows, depth grade, weapon clamp ----------------
    assign fy_nt    = {5'b0, centre_reg} - s2_reg.p_nt;
    assign fy_nb    = {5'b0, centre_reg} - s2_reg.p_nb;
    assign fy_ft    = {5'b0, centre_reg} - s2_reg.p_ft;
    assign fy_fb    = {5'b0, centre_reg} - s2_reg.p_fb;
    assign d_coarse = s2_reg.d_scaled[26:DEPTH_SHIFT];
    assign d_prod   = d_coarse * 33'(DEPTH_RECIP);

    always_comb
    begin
        s3_next         = '0;
        s3_next.req     = s2_reg.req;
        s3_next.keep    = s2_reg.keep;
        s3_next.x1      = s2_reg.x1;
        s3_next.x2      = s2_reg.x2;
        s3_next.mid     = s2_reg.mid;
        s3_next.nt      = clamp_to(CALC_W'($signed(fy_nt[31:16])), vh_reg);
        s3_next.nb      = clamp_to(CALC_W'($signed(fy_nb[31:16])), vh_reg);
        s3_next.ft      = clamp_to(CALC_W'($signed(fy_ft[31:16])), vh_reg);
        s3_next.fb      = clamp_to(CALC_W'($signed(fy_fb[31:16])), vh_reg);
        s3_next.shape   = s2_reg.shape;
        s3_next.thing   = s2_reg.thing;
        s3_next.gun_col = clamp_to(s2_reg.wx, vw_reg);
        s3_next.gun_row = clamp_to(s2_reg.wy, vh_reg);
        if (s2_reg.d_near)
        begin
            s3_next.depth = '0;
        end
        else if (s2_reg.d_far)
        begin
            s3_next.depth = DEPTH_MAX;
        end
        else
        begin
            s3_next.depth = DEPTH_MAX - d_prod[DEPTH_RECIP_SHIFT +: 10];
        end
    end

    // ---------------- stage 4: sprite height, result assembly ----------------
    assign thing_h = $signed({1'b0, s3_reg.nb}) - $signed({1'b0, s3_reg.nt});

    always_comb
    begin
        out_next      = '0;
        out_next.kind = s3_reg.req;
        if (s3_reg.keep)
        begin
            case (s3_reg.req)
                REQ_WALL:
                begin
                    out_next.keep            = 1'b1;
                    out_next.col_a           = s3_reg.x1;
                    out_next.col_b           = s3_reg.x2;
                    out_next.near_top_row    = s3_reg.nt;
                    out_next.near_bottom_row = s3_reg.nb;
                    out_next.far_top_row     = s3_reg.ft;
                    out_next.far_bottom_row  = s3_reg.fb;
                    out_next.depth           = s3_reg.depth;
                    out_next.shape_out       = s3_reg.shape;
                end
                REQ_SPRITE:
                begin
                    out_next.keep            = 1'b1;
                    out_next.col_a           = s3_reg.mid;
                    out_next.near_top_row    = s3_reg.nt;
                    out_next.near_bottom_row = s3_reg.nb;
                    out_next.depth           = s3_reg.depth;
                    out_next.kind_of_thing   = s3_reg.thing;
                    // short or upside-down sprites get the minimum height
                    if (thing_h < $signed({1'b0, MIN_THING_ROWS}))
                    begin
                        out_next.thing_rows = MIN_THING_ROWS;
                    end
                    else
                    begin
                        out_next.thing_rows = thing_h[COL_W-1:0];
                    end
                end
                REQ_WEAPON:
                begin
                    out_next.keep         = 1'b1;
                    out_next.col_a        = s3_reg.gun_col;
                    out_next.near_top_row = s3_reg.gun_row;
                end
                default: ;
            endcase
        end
    end

endmodule

// ----- verif/screen_projection_check.sv -----
// result checker for the screen projection block: predicts each request and compares results
module screen_projection_check (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_ready,
    input  spos_pkg::spos_item_t   item,
    input  logic                   result_valid,
    input  logic                   result_ready,
    input  spos_pkg::spos_result_t result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    output int                     mismatch_count,
    output int                     outstanding
);
    import spos_pkg::*;

    localparam int PRINT_CAP = 40;

    logic [10:0]        view_width_q  = VIEW_WIDTH_RST;
    logic [10:0]        view_height_q = VIEW_HEIGHT_RST;
    logic [26:0]        centre_row_q  = CENTRE_ROW_RST;
    logic signed [31:0] eye_height_q  = EYE_HEIGHT_RST;

    spos_result_t expected_projections[$];
    spos_result_t want;
    int           results_seen = 0;

    initial
    begin
        mismatch_count = 0;
        outstanding    = 0;
    end

    function automatic int side_in_use(input logic [10:0] raw);
        if (raw == 11'd0)
        begin
            return 1;
        end
        if (int'(raw) > MAX_SCREEN_SIDE)
        begin
            return MAX_SCREEN_SIDE;
        end
        return int'(raw);
    endfunction

    function automatic int fit_to_view(input int v, input int n);
        if (v < 0)
        begin
            return 0;
        end
        if (v >= n)
        begin
            return n - 1;
        end
        return v;
    endfunction

    // height above eye, scaled in 16.16, subtracted from the centre row
    function automatic int project_height(input logic signed [31:0] z,
                                          input logic signed [31:0] scale,
                                          input int vh);
        logic signed [31:0] rel;
        logic signed [63:0] prod;
        logic signed [31:0] fy;
        rel  = z - eye_height_q;
        prod = 64'(rel) * 64'(scale);
        fy   = 32'(centre_row_q) - prod[47:16];
        return fit_to_view(int'(fy >>> 16), vh);
    endfunction

    function automatic logic [9:0] depth_grade(input logic signed [31:0] s);
        int near_lim;
        int far_lim;
        near_lim = int'(NEAR_LIMIT);
        far_lim  = int'(FAR_LIMIT);
        if (int'(s) > near_lim)
        begin
            return 10'd0;
        end
        if (int'(s) < far_lim)
        begin
            return DEPTH_MAX;
        end
        return 10'(int'(DEPTH_MAX) -
                   ((int'(s) - far_lim) * int'(DEPTH_MAX)) / (near_lim - far_lim));
    endfunction

    function automatic logic signed [31:0] usable_scale(input logic signed [31:0] raw);
        return (raw <= 0) ? 32'sd1 : raw;
    endfunction

    function automatic spos_result_t project_request(input spos_item_t it);
        spos_result_t       r;
        int                 vw;
        int                 vh;
        int                 x1;
        int                 x2;
        int                 top;
        int                 bot;
        int                 h;
        logic               cols_ok;
        logic signed [31:0] s1;
        logic signed [31:0] s2;
        r       = '0;
        r.kind  = it.req_type;
        vw      = side_in_use(view_width_q);
        vh      = side_in_use(view_height_q);
        x1      = int'($signed(it.first_col));
        x2      = int'($signed(it.last_col));
        cols_ok = (x1 >= 0) && (x2 >= 0) && (x1 < vw) && (x2 < vw);
        s1      = usable_scale($signed(it.near_scale));
        s2      = usable_scale($signed(it.far_scale));
        case (it.req_type)
            REQ_WALL:
            begin
                if (cols_ok && x1 <= x2 && it.source_present)
                begin
                    r.keep            = 1'b1;
                    r.col_a           = 10'(x1);
                    r.col_b           = 10'(x2);
                    r.near_top_row    = 10'(project_height(it.top_z, s1, vh));
                    r.near_bottom_row = 10'(project_height(it.bottom_z, s1, vh));
                    r.far_top_row     = 10'(project_height(it.top_z, s2, vh));
                    r.far_bottom_row  = 10'(project_height(it.bottom_z, s2, vh));
                    r.depth           = depth_grade(s1);
                    r.shape_out       = it.wall_shape;
                end
            end
            REQ_SPRITE:
            begin
                if (cols_ok)
                begin
                    top = project_height(it.top_z, s1, vh);
                    bot = project_height(it.bottom_z, s1, vh);
                    h   = bot - top;
                    if (h < int'(MIN_THING_ROWS))
                    begin
                        h = int'(MIN_THING_ROWS);
                    end
                    r.keep            = 1'b1;
                    r.col_a           = 10'((x1 + x2) / 2);
                    r.near_top_row    = 10'(top);
                    r.near_bottom_row = 10'(bot);
                    r.depth           = depth_grade(s1);
                    r.kind_of_thing   = it.thing_kind;
                    r.thing_rows      = 10'(h);
                end
            end
            REQ_WEAPON:
            begin
                if (it.source_present)
                begin
                    r.keep         = 1'b1;
                    r.col_a        = 10'(fit_to_view(int'($signed(it.gun_x) >>> 16) + vw / 2,
                                                     vw));
                    r.near_top_row = 10'(fit_to_view(int'($signed(it.gun_y) >>> 16) + vh
                                                     - int'(GUN_RAISE), vh));
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_CAP)
        begin
            $display("mismatch, result %0d at %0t: %s", results_seen, $time, what);
        end
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int got, input int exp_val);
        if (got != exp_val)
        begin
            report_mismatch($sformatf("%s is %0d, should be %0d", name, got, exp_val));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_width_q  = VIEW_WIDTH_RST;
            view_height_q = VIEW_HEIGHT_RST;
            centre_row_q  = CENTRE_ROW_RST;
            eye_height_q  = EYE_HEIGHT_RST;
            expected_projections.delete();
            outstanding = 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                if (expected_projections.size() == 0)
                begin
                    report_mismatch("result with no request outstanding");
                end
                else
                begin
                    want = expected_projections.pop_front();
                    check_field("kind", int'(result.kind), int'(want.kind));
                    check_field("keep", int'(result.keep), int'(want.keep));
                    check_field("col_a", int'(result.col_a), int'(want.col_a));
                    check_field("col_b", int'(result.col_b), int'(want.col_b));
                    check_field("near_top_row", int'(result.near_top_row),
                                int'(want.near_top_row));
                    check_field("near_bottom_row", int'(result.near_bottom_row),
                                int'(want.near_bottom_row));
                    check_field("far_top_row", int'(result.far_top_row),
                                int'(want.far_top_row));
                    check_field("far_bottom_row", int'(result.far_bottom_row),
                                int'(want.far_bottom_row));
                    check_field("depth", int'(result.depth), int'(want.depth));
                    check_field("shape_out", int'(result.shape_out), int'(want.shape_out));
                    check_field("kind_of_thing", int'(result.kind_of_thing),
                                int'(want.kind_of_thing));
                    check_field("thing_rows", int'(result.thing_rows), int'(want.thing_rows));
                end
                results_seen++;
            end
            if (item_valid && item_ready)
            begin
                expected_projections.push_back(project_request(item));
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_VIEW_WIDTH:  view_width_q  = cfg_data[10:0];
                    CFG_VIEW_HEIGHT: view_height_q = cfg_data[10:0];
                    CFG_CENTRE_ROW:  centre_row_q  = cfg_data[26:0];
                    CFG_EYE_HEIGHT:  eye_height_q  = cfg_data;
                    default: ;
                endcase
            end
            outstanding = expected_projections.size();
        end
    end

endmodule

// ----- verif/screen_projection_of_segments_tb.sv -----
// testbench top for the screen projection block: stimulus, reset, clock and verdict
module screen_projection_of_segments_tb;
    import spos_pkg::*;

    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SETTLE      = 8;
    localparam logic [1:0] REQ_UNKNOWN = 2'd3;

    typedef enum {STEADY, MOSTLY_READY, MOSTLY_STALLED, LONG_STALLS} ready_mode_e;

    logic         clk = 1'b0;
    logic         rst_n;
    logic         item_valid;
    logic         item_ready;
    spos_item_t   item;
    logic         result_valid;
    logic         result_ready;
    spos_result_t result;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    int           mismatch_count;
    int           outstanding;

    // view as the stimulus sees it, to keep most columns and heights on screen
    int                 gen_vw  = 320;
    int                 gen_vh  = 168;
    logic signed [31:0] gen_eye = EYE_HEIGHT_RST;

    screen_projection_of_segments i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    screen_projection_check i_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .result_valid   (result_valid),
        .result_ready   (result_ready),
        .result         (result),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    always #5 clk = ~clk;

    function automatic int usable_side(input logic [10:0] raw);
        if (raw == 11'd0)
        begin
            return 1;
        end
        return (int'(raw) > MAX_SCREEN_SIDE) ? MAX_SCREEN_SIDE : int'(raw);
    endfunction

    function automatic logic signed [31:0] random_scale();
        case ($urandom_range(0, 7))
            0: return 32'($urandom);
            1: return -32'(int'($urandom_range(0, 100)));
            default: return 32'($urandom_range(32'h400, 32'h30000));
        endcase
    endfunction

    // mostly within a hundred rows of the eye, sometimes anywhere
    function automatic logic signed [31:0] random_height();
        if ($urandom_range(0, 7) == 0)
        begin
            return 32'($urandom);
        end
        return gen_eye + 32'(int'($urandom_range(0, 200 * 65536)) - 100 * 65536);
    endfunction

    function automatic logic signed [31:0] random_offset();
        if ($urandom_range(0, 5) == 0)
        begin
            return 32'($urandom);
        end
        return 32'((int'($urandom_range(0, 800)) - 400) * 65536 +
                   int'($urandom_range(0, 65535)));
    endfunction

    function automatic spos_item_t random_item();
        spos_item_t it;
        int         a;
        int         b;
        int         t;
        it.req_type = ($urandom_range(0, 29) == 0) ? REQ_UNKNOWN : 2'($urandom_range(0, 2));
        a = $urandom_range(0, gen_vw - 1);
        b = $urandom_range(0, gen_vw - 1);
        if (it.req_type == REQ_WALL && a > b)
        begin
            t = a;
            a = b;
            b = t;
        end
        it.first_col = 16'(a);
        it.last_col  = 16'(b);
        case ($urandom_range(0, 11))
            0: it.first_col = 16'($urandom);
            1: it.last_col  = 16'($urandom);
            2: it.last_col  = 16'(gen_vw + int'($urandom_range(0, 3)));
            3:
            begin
                it.first_col = 16'(b);
                it.last_col  = 16'(a);
            end
            default: ;
        endcase
        it.near_scale     = random_scale();
        it.far_scale      = random_scale();
        it.top_z          = random_height();
        it.bottom_z       = random_height();
        it.wall_shape     = 2'($urandom);
        it.thing_kind     = 8'($urandom);
        it.source_present = ($urandom_range(0, 9) != 0);
        it.gun_x          = random_offset();
        it.gun_y          = random_offset();
        return it;
    endfunction

    function automatic spos_item_t plain_item(input logic [1:0] req);
        spos_item_t it;
        it                = random_item();
        it.req_type       = req;
        it.first_col      = 16'sd10;
        it.last_col       = 16'sd100;
        it.near_scale     = 32'sh10000;
        it.far_scale      = 32'sh8000;
        it.top_z          = gen_eye + 32'sd1310720;
        it.bottom_z       = gen_eye - 32'sd1966080;
        it.source_present = 1'b1;
        return it;
    endfunction

    task automatic offer_item(input spos_item_t it);
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= it;
        @(posedge clk);
        while (!item_ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic rest(input int n);
        repeat (n)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
        end
    endtask

    // hold off until every request has its result, then let the pipe settle
    task automatic drain();
        @(negedge clk);
        item_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_view(input logic [31:0] w, input logic [31:0] h,
                            input logic [31:0] c, input logic [31:0] e);
        drain();
        write_reg(CFG_VIEW_WIDTH, w);
        write_reg(CFG_VIEW_HEIGHT, h);
        write_reg(CFG_CENTRE_ROW, c);
        write_reg(CFG_EYE_HEIGHT, e);
        gen_vw  = usable_side(w[10:0]);
        gen_vh  = usable_side(h[10:0]);
        gen_eye = e;
    endtask

    task automatic send_random(input int count);
        int left;
        left = $urandom_range(1, 16);
        for (int n = 0; n < count; n++)
        begin
            if (left == 0)
            begin
                if ($urandom_range(0, 39) == 0)
                begin
                    drain();
                end
                else
                begin
                    rest($urandom_range(1, 12));
                end
                left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
            end
            offer_item(random_item());
            left--;
        end
    endtask

    // receiver back-pressure
    initial
    begin
        ready_mode_e mode;
        int          mode_left;
        int          hold;
        logic        level;
        mode         = STEADY;
        mode_left    = 0;
        hold         = 0;
        level        = 1'b1;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = ready_mode_e'($urandom_range(0, 3));
                mode_left = $urandom_range(40, 300);
            end
            mode_left--;
            case (mode)
                STEADY:         result_ready <= 1'b1;
                MOSTLY_READY:   result_ready <= ($urandom_range(0, 3) != 0);
                MOSTLY_STALLED: result_ready <= ($urandom_range(0, 3) == 0);
                default:
                begin
                    if (hold == 0)
                    begin
                        level = !level;
                        hold  = level ? $urandom_range(1, 4) : $urandom_range(8, 40);
                    end
                    hold--;
                    result_ready <= level;
                end
            endcase
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        spos_item_t  it;
        int          rows;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_VIEW_WIDTH;
        cfg_data     = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // walls at reset view: scale and height extremes, then each skip reason
        it = plain_item(REQ_WALL);
        it.first_col  = 16'sd0;
        it.last_col   = 16'sd319;
        it.near_scale = 32'sh7fffffff;
        it.far_scale  = 32'sh80000000;
        it.top_z      = 32'sh7fffffff;
        it.bottom_z   = 32'sh80000000;
        offer_item(it);
        it = plain_item(REQ_WALL);
        it.near_scale = 32'sh0;
        it.far_scale  = 32'sh800;
        offer_item(it);
        it = plain_item(REQ_WALL);
        it.near_scale = 32'sh20000;
        it.far_scale  = 32'sh20001;
        it.wall_shape = 2'd3;
        offer_item(it);
        it = plain_item(REQ_WALL);
        it.near_scale = 32'sh7ff;
        it.far_scale  = 32'sh801;
        it.first_col  = 16'sd319;
        it.last_col   = 16'sd319;
        offer_item(it);
        it = plain_item(REQ_WALL);
        it.first_col = -16'sd1;
        offer_item(it);
        it = plain_item(REQ_WALL);
        it.last_col = 16'sd320;
        offer_item(it);
        it = plain_item(REQ_WALL);
        it.first_col = 16'sd11;
        it.last_col  = 16'sd10;
        offer_item(it);
        it = plain_item(REQ_WALL);
        it.source_present = 1'b0;
        offer_item(it);
        it = plain_item(REQ_WALL);
        it.first_col = 16'sh7fff;
        it.last_col  = 16'sh7fff;
        offer_item(it);
        it = plain_item(REQ_WALL);
        it.first_col = 16'sh8000;
        offer_item(it);

        // sprites: source flag ignored, height floor, reversed columns, off-screen
        it = plain_item(REQ_SPRITE);
        it.source_present = 1'b0;
        it.thing_kind     = 8'hff;
        offer_item(it);
        it = plain_item(REQ_SPRITE);
        it.bottom_z = it.top_z;
        offer_item(it);
        it = plain_item(REQ_SPRITE);
        it.top_z    = gen_eye - 32'sd1966080;
        it.bottom_z = gen_eye + 32'sd1310720;
        offer_item(it);
        it = plain_item(REQ_SPRITE);
        it.first_col = 16'sd300;
        it.last_col  = 16'sd5;
        it.near_scale = 32'sh80000000;
        offer_item(it);
        it = plain_item(REQ_SPRITE);
        it.last_col = 16'sh8000;
        offer_item(it);
        it = plain_item(REQ_SPRITE);
        it.first_col = 16'sd320;
        offer_item(it);

        // weapon: hidden, then offsets at both ends and at zero; then an unknown request
        it = plain_item(REQ_WEAPON);
        it.source_present = 1'b0;
        offer_item(it);
        it = plain_item(REQ_WEAPON);
        it.gun_x = 32'sh7fffffff;
        it.gun_y = 32'sh80000000;
        offer_item(it);
        it = plain_item(REQ_WEAPON);
        it.gun_x = 32'sh80000000;
        it.gun_y = 32'sh7fffffff;
        offer_item(it);
        it = plain_item(REQ_WEAPON);
        it.gun_x = 32'sh0;
        it.gun_y = 32'sh0;
        offer_item(it);
        offer_item(plain_item(REQ_UNKNOWN));

        send_random(180);

        set_view(32'd1024, 32'd1024, 32'd512 << 16, 32'd0);
        send_random(200);
        set_view(32'd1, 32'd1, 32'd0, 32'h7fffffff);
        send_random(200);
        set_view(32'd2047, 32'hfffff800, 32'hffffffff, 32'h80000000);
        send_random(200);
        rows = $urandom_range(16, 1024);
        set_view(32'($urandom_range(16, 1024)), 32'(rows),
                 32'(rows * 32768 + int'($urandom_range(0, 65535))),
                 32'(int'($urandom_range(0, 100 * 65536)) - 50 * 65536));
        send_random(200);
        set_view({21'($urandom), 11'd320}, {21'($urandom), 11'd200},
                 {5'($urandom), 27'(100 * 65536)}, 32'd41 << 16);
        send_random(200);
        set_view($urandom, $urandom, $urandom, $urandom);
        send_random(200);
        set_view(32'd640, 32'd480, 32'd240 << 16, 32'h00300000);
        send_random(200);

        drain();
        if (mismatch_count == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/core/spos_pkg.sv
rtl/core/screen_projection_of_segments.sv
verif/screen_projection_check.sv
verif/screen_projection_of_segments_tb.sv
